// ===== src/psv_pkg.sv =====
`default_nettype none

package psv_pkg;

   // Width of the byte counter and of the reported section size.
   localparam int unsigned SIZE_WIDTH = 13;
   localparam int unsigned LENGTH_WIDTH = 12;
   localparam int unsigned CRC_WIDTH = 32;
   localparam int unsigned MODE_WIDTH = 2;

   localparam int unsigned MAX_SECTION_BYTES_DEFAULT = 4096;
   localparam int unsigned MIN_SHORT_BYTES = 3;
   localparam int unsigned MIN_LONG_BYTES = 12;

   // Header byte positions within a section, and the byte count at which the CRC delay line is full.
   localparam logic [SIZE_WIDTH-1:0] POS_LENGTH_HI = 13'd1;
   localparam logic [SIZE_WIDTH-1:0] POS_LENGTH_LO = 13'd2;
   localparam logic [SIZE_WIDTH-1:0] POS_TAIL_FULL = 13'd4;
   localparam logic [SIZE_WIDTH-1:0] POS_SECTION_NUM = 13'd6;
   localparam logic [SIZE_WIDTH-1:0] POS_LAST_SECTION_NUM = 13'd7;

   localparam logic [CRC_WIDTH-1:0] CRC_POLY = 32'h04C1_1DB7;
   localparam logic [CRC_WIDTH-1:0] CRC_INIT = 32'hFFFF_FFFF;

   // CRC mode register codes; the unused code behaves like ignore.
   localparam logic [MODE_WIDTH-1:0] CRC_MODE_CHECK = 2'd0;
   localparam logic [MODE_WIDTH-1:0] CRC_MODE_COMPUTE = 2'd1;
   localparam logic [MODE_WIDTH-1:0] CRC_MODE_IGNORE = 2'd2;

   typedef struct packed {
      logic                  section_valid;
      logic                  long_section;
      logic [SIZE_WIDTH-1:0] section_size;
      logic [CRC_WIDTH-1:0]  computed_crc;
      logic                  crc_matched;
   } verdict_type;

   // MPEG-2 CRC32, MSB first, one byte.
   function automatic logic [CRC_WIDTH-1:0] crc_absorb(input logic [CRC_WIDTH-1:0] crc,
                                                       input logic [7:0] data);
      logic [CRC_WIDTH-1:0] c;
      c = crc ^ {data, 24'h0};
      for (int i = 0; i < 8; i++) begin
         if (c[CRC_WIDTH-1]) begin
            c = {c[CRC_WIDTH-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_WIDTH-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== src/psi_section_validator.sv =====
// PSI section validator.
// Feed one section byte per item on the req_ channel, header first, with
// req_last_byte set on the final byte of the section. Each item marked last
// yields one verdict item on the rsp_ channel: overall validity, long-section
// flag, saturating byte count, the CRC32 over all but the last four bytes of a
// long section (zero otherwise) and the CRC match flag. Other items yield nothing.
// Throughput: one byte per cycle unless a last byte waits on a verdict not yet taken;
// the per-byte CRC update is a single 8-bit step of the MPEG-2 CRC32 between two registers.
// A verdict passes through the input register, then the result register, after its last
// byte is accepted; it waits in the input register while an untaken verdict occupies the result register.
// csr_wr_en/csr_wr_data set the CRC mode (check, compute, ignore); write it
// only while no section is in flight.
// Reset clears the section state, sets the CRC mode to check and empties both channel registers.
// When the receiver stalls, the held verdict stays in the result register;
// non-last bytes keep flowing, and a second last byte waits in the input
// register, which then drops req_ready until the verdict is taken.
`default_nettype none

module psi_section_validator #(
   parameter int unsigned MAX_SECTION_BYTES = psv_pkg::MAX_SECTION_BYTES_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,

   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [7:0]                     req_section_byte,
   input  wire logic                           req_last_byte,

   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_section_valid,
   output logic                                rsp_long_section,
   output logic [psv_pkg::SIZE_WIDTH-1:0]      rsp_section_size,
   output logic [psv_pkg::CRC_WIDTH-1:0]       rsp_computed_crc,
   output logic                                rsp_crc_matched,

   input  wire logic                           csr_wr_en,
   input  wire logic [psv_pkg::MODE_WIDTH-1:0] csr_wr_data
);

   logic                            in_valid_ff, in_valid_in;
   logic [7:0]                      in_byte_ff;
   logic                            in_last_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   psv_pkg::verdict_type            verdict, rsp_ff;
   logic [psv_pkg::MODE_WIDTH-1:0]  mode_ff;
   logic                            advance;
   logic                            accept;

   // Advance the held byte unless it is a last byte and the result slot is
   // still occupied by a verdict that is not being taken.
   assign advance   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   psv_section_core #(
      .MAX_SECTION_BYTES(MAX_SECTION_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .section_byte(in_byte_ff),
      .last_byte   (in_last_ff),
      .crc_mode    (mode_ff),
      .verdict     (verdict)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= psv_pkg::CRC_MODE_CHECK;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers: capture on accept, load the verdict on a last byte.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_section_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance && in_last_ff) begin
         rsp_ff <= verdict;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_section_valid = rsp_ff.section_valid;
   assign rsp_long_section  = rsp_ff.long_section;
   assign rsp_section_size  = rsp_ff.section_size;
   assign rsp_computed_crc  = rsp_ff.computed_crc;
   assign rsp_crc_matched   = rsp_ff.crc_matched;

endmodule

`default_nettype wire

// ===== src/psv_section_core.sv =====
`default_nettype none

module psv_section_core #(
   parameter int unsigned MAX_SECTION_BYTES = psv_pkg::MAX_SECTION_BYTES_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            step,
   input  wire logic [7:0]                      section_byte,
   input  wire logic                            last_byte,
   input  wire logic [psv_pkg::MODE_WIDTH-1:0]  crc_mode,
   output psv_pkg::verdict_type                 verdict
);

   localparam int unsigned SW = psv_pkg::SIZE_WIDTH;
   localparam int unsigned LW = psv_pkg::LENGTH_WIDTH;
   localparam logic [SW-1:0] SAT_COUNT = SW'(MAX_SECTION_BYTES + 1);
   localparam logic [SW-1:0] MAX_COUNT = SW'(MAX_SECTION_BYTES);
   localparam logic [SW-1:0] MIN_SHORT = SW'(psv_pkg::MIN_SHORT_BYTES);
   localparam logic [SW-1:0] MIN_LONG = SW'(psv_pkg::MIN_LONG_BYTES);
   localparam logic [SW-1:0] HEADER_BYTES = SW'(3);

   logic [SW-1:0]                    count_ff, count_in;
   logic [LW-1:0]                    length_ff, length_in;
   logic                             syntax_ff, syntax_in;
   logic [7:0]                       sect_num_ff, sect_num_in;
   logic [7:0]                       last_num_ff, last_num_in;
   logic [psv_pkg::CRC_WIDTH-1:0]    crc_ff, crc_in;
   logic [3:0][7:0]                  tail_ff, tail_in;

   logic size_ok, length_ok, is_long, matched, valid;
   logic [psv_pkg::CRC_WIDTH-1:0] stored_crc;

   // Next section state for this byte.
   always_comb begin
      length_in   = length_ff;
      syntax_in   = syntax_ff;
      sect_num_in = sect_num_ff;
      last_num_in = last_num_ff;
      if (count_ff == psv_pkg::POS_LENGTH_HI) begin
         syntax_in = section_byte[7];
         length_in = {section_byte[3:0], length_ff[7:0]};
      end else if (count_ff == psv_pkg::POS_LENGTH_LO) begin
         length_in = {length_ff[LW-1:8], section_byte};
      end else if (count_ff == psv_pkg::POS_SECTION_NUM) begin
         sect_num_in = section_byte;
      end else if (count_ff == psv_pkg::POS_LAST_SECTION_NUM) begin
         last_num_in = section_byte;
      end

      // The oldest held byte enters the CRC once the delay line is full.
      crc_in = (count_ff >= psv_pkg::POS_TAIL_FULL) ?
               psv_pkg::crc_absorb(crc_ff, tail_ff[0]) : crc_ff;
      tail_in = {section_byte, tail_ff[3], tail_ff[2], tail_ff[1]};

      count_in = (count_ff < SAT_COUNT) ? count_ff + SW'(1) : count_ff;
   end

   // Verdict from the updated state.
   always_comb begin
      stored_crc = {tail_in[0], tail_in[1], tail_in[2], tail_in[3]};
      size_ok    = (count_in >= MIN_SHORT) && (count_in <= MAX_COUNT);
      length_ok  = size_ok && ({1'b0, length_in} == (count_in - HEADER_BYTES));
      is_long    = length_ok && syntax_in && (count_in >= MIN_LONG);
      matched    = is_long && (crc_in == stored_crc);
      valid      = length_ok;
      if (is_long) begin
         valid = (sect_num_in <= last_num_in) &&
                 (matched || (crc_mode != psv_pkg::CRC_MODE_CHECK));
      end

      verdict.section_valid = valid;
      verdict.long_section  = is_long;
      verdict.section_size  = count_in;
      verdict.computed_crc  = is_long ? crc_in : '0;
      verdict.crc_matched   = matched;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         count_ff    <= '0;
         length_ff   <= '0;
         syntax_ff   <= 1'b0;
         sect_num_ff <= '0;
         last_num_ff <= '0;
         crc_ff      <= psv_pkg::CRC_INIT;
         tail_ff     <= '0;
      end else if (step) begin
         count_ff    <= count_in;
         length_ff   <= length_in;
         syntax_ff   <= syntax_in;
         sect_num_ff <= sect_num_in;
         last_num_ff <= last_num_in;
         crc_ff      <= crc_in;
         tail_ff     <= tail_in;
      end
   end

endmodule

`default_nettype wire
